@@ rtl/rgblz_pkg.sv @@
package rgblz_pkg;

	// sizing
	localparam int MAX_WIDTH     = 1024;
	localparam int HISTORY_DEPTH = 16384;
	localparam int HA_W          = $clog2(HISTORY_DEPTH);
	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 24;
	localparam int PEND_W        = 18;
	localparam int WIDTH_W       = 11;
	localparam int ROW_W         = $clog2(MAX_WIDTH + 1);
	localparam int WX_W          = (ROW_W > WIDTH_W) ? ROW_W : WIDTH_W;
	localparam int DIST_W        = $clog2(3 * (4 * MAX_WIDTH + 6) + 1);
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 24;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_LENGTH   = 2'd2;

	// item modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_PULL = 1'b1;

	// stream format
	localparam logic [BYTE_W-1:0] FLAG_COPY     = 8'h80;
	localparam logic [BYTE_W-1:0] FLAG_LONG_LIT = 8'h7f;
	localparam logic [1:0]        SHORT_LONG    = 2'd3;
	localparam int                HDR_BYTES     = 3;
	localparam int                LONG_LIT_BIAS = 128;
	localparam int                LONG_CPY_BIAS = 4;

	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_DONE    = 2'd1,
		ST_ERROR   = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		PH_HDR  = 6'b000001,
		PH_FLAG = 6'b000010,
		PH_LO   = 6'b000100,
		PH_HI   = 6'b001000,
		PH_LIT  = 6'b010000,
		PH_COPY = 6'b100000
	} phase_t;

	typedef struct packed {
		logic              mode;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		status_t           status;
		logic              last;
	} result_t;

	// one decoded step handed from the parser to the output stage
	typedef struct packed {
		logic              has_res;
		logic              emit;
		logic              from_mem;
		logic              zero;
		logic [BYTE_W-1:0] value;
		status_t           status;
		logic              last;
		logic [HA_W-1:0]   waddr;
	} op_t;

	// neighbor table: pixel step k and row count m
	function automatic logic signed [3:0] ofs_k(input logic [4:0] sel);
		int s;
		int k;
		s = int'(sel);
		if (s < 6)       k = -1 - s;
		else if (s < 13) k = 9 - s;
		else if (s < 20) k = 16 - s;
		else if (s < 27) k = 23 - s;
		else             k = 29 - s;
		return 4'(k);
	endfunction

	function automatic logic [2:0] ofs_m(input logic [4:0] sel);
		logic [2:0] m;
		if (sel < 5'd6)       m = 3'd0;
		else if (sel < 5'd13) m = 3'd1;
		else if (sel < 5'd20) m = 3'd2;
		else if (sel < 5'd27) m = 3'd3;
		else                  m = 3'd4;
		return m;
	endfunction

endpackage

@@ rtl/rgb_image_lz_decoder_core.sv @@
// a taken item's result passes the history read stage, then the output register
// throughput: one push or pull item per cycle while ready is high; each copy pull is one ram read
// ready is low in the cycle after any register write so the neighbor distance can settle
// reset: async active low resets config registers, counters, phase, stop flag and output valid flags
// the history ram is not cleared; a source before the first output byte reads as zero, not ram data
module rgb_image_lz_decoder_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  rgblz_pkg::item_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output rgblz_pkg::result_t                    result,
	input  logic                                  cfg_we,
	input  logic [rgblz_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rgblz_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                              accept;
	logic                              space;
	logic                              cfg_hold;
	rgblz_pkg::op_t                    op;
	logic                              hist_re;
	logic [rgblz_pkg::HA_W-1:0]        hist_raddr;
	logic                              hist_we;
	logic [rgblz_pkg::HA_W-1:0]        hist_waddr;
	logic [rgblz_pkg::BYTE_W-1:0]      hist_wdata;
	logic [rgblz_pkg::BYTE_W-1:0]      hist_rdata;

	// an item can enter whenever the stage after the ram has room and ready is not held
	// after a register write, even while a finished result waits in the output register
	assign item_ready = space && !cfg_hold;
	assign accept     = item_valid && item_ready;

	// parser: stream state machine, counters, length checks, source address
	rgblz_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg_hold   (cfg_hold),
		.op         (op),
		.hist_re    (hist_re),
		.hist_raddr (hist_raddr)
	);

	// history ring of decoded bytes, one read and one write port
	rgblz_ram #(
		.WIDTH (rgblz_pkg::BYTE_W),
		.DEPTH (rgblz_pkg::HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// read-data stage and output register; writes each emitted byte back
	// to history as it leaves the stage (sources are always at least three
	// bytes back, so a read never meets a pending write)
	rgblz_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (op),
		.ram_rdata    (hist_rdata),
		.space        (space),
		.hist_we      (hist_we),
		.hist_waddr   (hist_waddr),
		.hist_wdata   (hist_wdata),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ rtl/rgblz_ram.sv @@
module rgblz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/rgblz_parser.sv @@
module rgblz_parser (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  rgblz_pkg::item_t                      item,
	input  logic                                  cfg_we,
	input  logic [rgblz_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rgblz_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                  cfg_hold,
	output rgblz_pkg::op_t                        op,
	output logic                                  hist_re,
	output logic [rgblz_pkg::HA_W-1:0]            hist_raddr
);

	localparam int BACK_W = rgblz_pkg::ROW_W + 4;
	localparam int MW_W   = rgblz_pkg::ROW_W + 3;
	localparam int CNT_W  = rgblz_pkg::CNT_W;
	localparam int PEND_W = rgblz_pkg::PEND_W;

	logic [rgblz_pkg::WIDTH_W-1:0] width_q;
	logic [CNT_W-1:0]              out_len_q;
	logic [CNT_W-1:0]              in_len_q;
	logic                          cfg_hold_q;

	logic [CNT_W-1:0]  out_cnt_q, out_cnt_d, out_cnt_inc;
	logic [CNT_W-1:0]  in_cnt_q, in_cnt_d, in_cnt_inc;
	rgblz_pkg::phase_t phase_q, phase_d;
	logic [PEND_W-1:0] pend_q, pend_d;
	logic [4:0]        sel_q, sel_d;
	logic [7:0]        len_lo_q, len_lo_d;
	logic              run_copy_q, run_copy_d;
	logic              stopped_q, stopped_d;
	logic [rgblz_pkg::DIST_W-1:0] dist_q, dist_d;
	logic              src_none_q, src_none_d;

	// offset from the selected neighbor
	logic [rgblz_pkg::WX_W-1:0]  w_ext, w_cl;
	logic [rgblz_pkg::ROW_W-1:0] w_row;
	logic [MW_W-1:0]             mw;
	logic signed [BACK_W-1:0]    back;

	logic [CNT_W:0]    src_diff;
	logic              src_before;

	// run lengths
	logic [16:0]       hi_base;
	logic [PEND_W-1:0] hi_len3;
	logic [PEND_W-1:0] flag_lit_len;
	logic [PEND_W-1:0] short_cpy_len;
	logic [PEND_W-1:0] lit_len;
	logic              lit_over;
	logic              len_over;

	logic do_emit, do_fail, do_refuse, do_lit, need_len, pull;

	// width clamp and neighbor distance, registered for the next pull
	always_comb begin
		w_ext = rgblz_pkg::WX_W'(width_q);
		if (w_ext == '0) begin
			w_cl = rgblz_pkg::WX_W'(1);
		end else if (w_ext > rgblz_pkg::WX_W'(rgblz_pkg::MAX_WIDTH)) begin
			w_cl = rgblz_pkg::WX_W'(rgblz_pkg::MAX_WIDTH);
		end else begin
			w_cl = w_ext;
		end
		w_row = w_cl[rgblz_pkg::ROW_W-1:0];
		mw    = MW_W'(rgblz_pkg::ofs_m(sel_d)) * MW_W'(w_row);
		back  = $signed({1'b0, mw}) - BACK_W'(rgblz_pkg::ofs_k(sel_d));
		src_none_d = back[BACK_W-1] || (back == '0);
		dist_d     = rgblz_pkg::DIST_W'(back[MW_W-1:0]) * rgblz_pkg::DIST_W'(3);
	end

	assign out_cnt_inc = out_cnt_q + CNT_W'(1);
	assign in_cnt_inc  = in_cnt_q + CNT_W'(1);
	assign src_diff    = {1'b0, out_cnt_q} - (CNT_W + 1)'(dist_q);
	assign src_before  = src_diff[CNT_W];
	assign hist_raddr  = src_diff[rgblz_pkg::HA_W-1:0];

	assign hi_base = {1'b0, item.data_byte, len_lo_q}
		+ (run_copy_q ? 17'(rgblz_pkg::LONG_CPY_BIAS) : 17'(rgblz_pkg::LONG_LIT_BIAS));
	assign hi_len3       = PEND_W'(hi_base) * PEND_W'(3);
	assign flag_lit_len  = PEND_W'(item.data_byte) * PEND_W'(3) + PEND_W'(3);
	assign short_cpy_len = PEND_W'(item.data_byte[1:0]) * PEND_W'(3) + PEND_W'(3);
	assign lit_len       = (phase_q == rgblz_pkg::PH_HI) ? hi_len3 : flag_lit_len;

	assign lit_over = ({1'b0, in_cnt_inc} + (CNT_W + 1)'(lit_len) > {1'b0, in_len_q})
		|| ({1'b0, out_cnt_q} + (CNT_W + 1)'(lit_len) > {1'b0, out_len_q});
	assign len_over = ({1'b0, in_cnt_inc} + (CNT_W + 1)'(1) >= {1'b0, in_len_q});

	always_comb begin
		phase_d    = phase_q;
		pend_d     = pend_q;
		sel_d      = sel_q;
		len_lo_d   = len_lo_q;
		run_copy_d = run_copy_q;
		stopped_d  = stopped_q;
		out_cnt_d  = out_cnt_q;
		in_cnt_d   = in_cnt_q;
		hist_re    = 1'b0;
		do_emit    = 1'b0;
		do_fail    = 1'b0;
		do_refuse  = 1'b0;
		do_lit     = 1'b0;
		need_len   = 1'b0;
		pull       = 1'b0;

		if (accept) begin
			if (stopped_q) begin
				do_refuse = 1'b1;
			end else if (phase_q == rgblz_pkg::PH_COPY) begin
				if (item.mode != rgblz_pkg::MODE_PULL) begin
					do_refuse = 1'b1;
				end else begin
					pend_d = pend_q - PEND_W'(1);
					if (pend_q == PEND_W'(1)) begin
						phase_d = rgblz_pkg::PH_FLAG;
					end
					hist_re = 1'b1;
					pull    = 1'b1;
					do_emit = 1'b1;
				end
			end else if (item.mode != rgblz_pkg::MODE_PUSH) begin
				do_refuse = 1'b1;
			end else if (in_cnt_q >= in_len_q) begin
				do_fail = 1'b1;
			end else begin
				in_cnt_d = in_cnt_inc;
				case (phase_q)
					rgblz_pkg::PH_HDR: begin
						if (in_cnt_inc >= CNT_W'(rgblz_pkg::HDR_BYTES)) begin
							phase_d = rgblz_pkg::PH_FLAG;
						end
						do_emit = 1'b1;
					end
					rgblz_pkg::PH_FLAG: begin
						if (item.data_byte < rgblz_pkg::FLAG_COPY) begin
							if (item.data_byte != rgblz_pkg::FLAG_LONG_LIT) begin
								do_lit = 1'b1;
							end else begin
								run_copy_d = 1'b0;
								need_len   = 1'b1;
							end
						end else begin
							sel_d = item.data_byte[6:2];
							if (item.data_byte[1:0] != rgblz_pkg::SHORT_LONG) begin
								pend_d  = short_cpy_len;
								phase_d = rgblz_pkg::PH_COPY;
							end else begin
								run_copy_d = 1'b1;
								need_len   = 1'b1;
							end
						end
					end
					rgblz_pkg::PH_LO: begin
						len_lo_d = item.data_byte;
						phase_d  = rgblz_pkg::PH_HI;
					end
					rgblz_pkg::PH_HI: begin
						if (run_copy_q) begin
							pend_d  = hi_len3;
							phase_d = rgblz_pkg::PH_COPY;
						end else begin
							do_lit = 1'b1;
						end
					end
					default: begin
						// literal run body
						pend_d = pend_q - PEND_W'(1);
						if (pend_q == PEND_W'(1)) begin
							phase_d = rgblz_pkg::PH_FLAG;
						end
						do_emit = 1'b1;
					end
				endcase
			end
		end

		if (do_lit) begin
			if (lit_over) begin
				do_fail = 1'b1;
			end else begin
				pend_d  = lit_len;
				phase_d = rgblz_pkg::PH_LIT;
			end
		end
		if (need_len) begin
			if (len_over) begin
				do_fail = 1'b1;
			end else begin
				phase_d = rgblz_pkg::PH_LO;
			end
		end

		op        = '0;
		op.value  = item.data_byte;
		op.status = rgblz_pkg::ST_DATA;
		op.waddr  = out_cnt_q[rgblz_pkg::HA_W-1:0];
		if (do_refuse) begin
			op.has_res = 1'b1;
			op.value   = '0;
			op.status  = rgblz_pkg::ST_REFUSED;
		end else if (do_fail) begin
			op.has_res = 1'b1;
			op.value   = '0;
			op.status  = rgblz_pkg::ST_ERROR;
			op.last    = 1'b1;
			stopped_d  = 1'b1;
		end else if (do_emit) begin
			op.has_res  = 1'b1;
			op.emit     = 1'b1;
			op.from_mem = pull;
			op.zero     = src_none_q || src_before;
			out_cnt_d   = out_cnt_inc;
			if (out_cnt_inc >= out_len_q) begin
				op.status = rgblz_pkg::ST_DONE;
				op.last   = 1'b1;
				stopped_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= rgblz_pkg::WIDTH_W'(1);
			out_len_q  <= '0;
			in_len_q   <= '0;
			cfg_hold_q <= 1'b0;
			out_cnt_q  <= '0;
			in_cnt_q   <= '0;
			phase_q    <= rgblz_pkg::PH_HDR;
			pend_q     <= '0;
			sel_q      <= '0;
			len_lo_q   <= '0;
			run_copy_q <= 1'b0;
			stopped_q  <= 1'b0;
			dist_q     <= '0;
			src_none_q <= 1'b1;
		end else begin
			cfg_hold_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					rgblz_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data[rgblz_pkg::WIDTH_W-1:0];
					rgblz_pkg::CFG_OUT_LENGTH:  out_len_q <= cfg_data[CNT_W-1:0];
					rgblz_pkg::CFG_IN_LENGTH:   in_len_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			out_cnt_q  <= out_cnt_d;
			in_cnt_q   <= in_cnt_d;
			phase_q    <= phase_d;
			pend_q     <= pend_d;
			sel_q      <= sel_d;
			len_lo_q   <= len_lo_d;
			run_copy_q <= run_copy_d;
			stopped_q  <= stopped_d;
			dist_q     <= dist_d;
			src_none_q <= src_none_d;
		end
	end

	assign cfg_hold = cfg_hold_q;

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("decoder left the stopped state");

	a_stop_refuses: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stopped_q |-> op.has_res && op.status == rgblz_pkg::ST_REFUSED)
		else $error("item taken after stop was not refused");

	a_read_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		hist_re |-> accept && phase_q == rgblz_pkg::PH_COPY && op.from_mem)
		else $error("history read outside a copy pull");

endmodule

@@ rtl/rgblz_out.sv @@
module rgblz_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  rgblz_pkg::op_t                     op,
	input  logic [rgblz_pkg::BYTE_W-1:0]       ram_rdata,
	output logic                               space,
	output logic                               hist_we,
	output logic [rgblz_pkg::HA_W-1:0]         hist_waddr,
	output logic [rgblz_pkg::BYTE_W-1:0]       hist_wdata,
	output logic                               result_valid,
	input  logic                               result_ready,
	output rgblz_pkg::result_t                 result
);

	logic                          s1_valid_s1;
	rgblz_pkg::op_t                op_s1;
	logic                          s1_move;
	logic [rgblz_pkg::BYTE_W-1:0]  s1_byte;
	logic                          out_valid_q;
	rgblz_pkg::result_t            result_q;

	assign s1_move = !out_valid_q || result_ready;
	assign space   = !s1_valid_s1 || s1_move;

	// copy bytes come from the history read issued at accept, or are zero when the source is flagged as none
	assign s1_byte = op_s1.from_mem ? (op_s1.zero ? '0 : ram_rdata) : op_s1.value;

	assign hist_we    = s1_valid_s1 && s1_move && op_s1.emit;
	assign hist_waddr = op_s1.waddr;
	assign hist_wdata = s1_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && op.has_res) begin
				s1_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				s1_valid_s1 <= 1'b0;
			end
			if (s1_valid_s1 && s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op.has_res) begin
			op_s1 <= op;
		end
		if (s1_valid_s1 && s1_move) begin
			result_q.out_byte <= s1_byte;
			result_q.status   <= op_s1.status;
			result_q.last     <= op_s1.last;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && !s1_move |=> s1_valid_s1 && $stable(op_s1))
		else $error("stalled stage lost its item");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> space)
		else $error("item taken with no room in the output stage");

endmodule
